// ----- src/cht_pkg.sv -----
// Shared types and constants for the chained hash table block.
// Holds sizes, status codes and the packed records kept in the RAMs.
// Depends on nothing; the top level and the hash unit refer to it by scoped names.
`default_nettype none

package cht_pkg;

	// Sizes of the entry pool and of the bucket table.
	localparam int POOL_ENTRIES = 32;
	localparam int MAX_BUCKETS  = 16;

	// Field widths.
	localparam int KEY_W   = 31;
	localparam int VAL_W   = 16;
	localparam int CFG_W   = 5;
	localparam int SLOT_W  = $clog2(POOL_ENTRIES);
	localparam int CNT_W   = $clog2(POOL_ENTRIES + 1);
	localparam int BKT_W   = $clog2(MAX_BUCKETS);
	localparam int DVD_W   = KEY_W + 2;
	localparam int STEP_W  = $clog2(DVD_W + 1);

	// Bucket count after reset.
	localparam logic [CFG_W-1:0] BUCKETS_RESET = CFG_W'(10);

	// Result status codes.
	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_DUMPED   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// One stored entry.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	// First and last slot of one bucket chain.
	typedef struct packed {
		logic [SLOT_W-1:0] head;
		logic [SLOT_W-1:0] tail;
	} bucket_t;

	// Response of the hash unit.
	typedef struct packed {
		logic             done;
		logic [BKT_W-1:0] rem;
	} mod_rsp_t;

endpackage

`default_nettype wire

// ----- src/chained_hash_table_insert_dump.sv -----
// Chained hash table with insert and dump, top level.
// Depends on cht_pkg, cht_ram (entry and bucket RAMs) and cht_mod (hash unit).
//
// Usage: the input channel (in_valid/in_ready) carries action, key and value.
// An insert (action 0) appends the entry to the tail of bucket
// (3*key+1) mod bucket_count and answers one result with status inserted,
// or pool full once all 32 slots are taken. A dump (action 1) lists every
// entry bucket by bucket, in insertion order within a bucket, marking the
// final result with last; an empty table answers one empty result.
// One item is worked on at a time; in_ready is high only while idle.
// An insert steps through the hash unit (one step per dividend bit), then the
// bucket read, the write back and the output load; in_ready returns as the
// result is loaded, so each insert ends before the next item is taken.
// A dump reads the bucket table once per occupied bucket, steps over empty
// buckets one by one, and reads one entry per result from the entry RAM.
// Results pass through one output register; when the receiver stalls,
// the walk holds its RAM read data and resumes when the transfer completes.
// Reset empties the table (bucket valid bits and fill count cleared, no
// clearing pass) and sets bucket_count to 10. cfg_we writes bucket_count
// at once; a value of 0 acts as 1 and values above 16 act as 16.
`default_nettype none

module chained_hash_table_insert_dump (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         action,
	input  wire logic [cht_pkg::KEY_W-1:0]    key,
	input  wire logic [cht_pkg::VAL_W-1:0]    value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [1:0]                   status,
	output logic      [cht_pkg::KEY_W-1:0]    out_key,
	output logic      [cht_pkg::VAL_W-1:0]    out_value,
	output logic                              last,
	input  wire logic                         cfg_we,
	input  wire logic [cht_pkg::CFG_W-1:0]    cfg_wdata
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_HASH  = 7'b0000010,
		S_BRD   = 7'b0000100,
		S_EMIT  = 7'b0001000,
		S_DSCAN = 7'b0010000,
		S_DHEAD = 7'b0100000,
		S_DOUT  = 7'b1000000
	} state_t;

	state_t                            state_q;
	logic [cht_pkg::CFG_W-1:0]         bcount_q;
	logic [cht_pkg::BKT_W:0]           eff_buckets;
	logic [cht_pkg::CNT_W-1:0]         used_q;
	logic [cht_pkg::MAX_BUCKETS-1:0]   bvalid_q;
	logic [cht_pkg::BKT_W-1:0]         bkt_q;
	logic [cht_pkg::SLOT_W-1:0]        cur_q;
	logic [cht_pkg::SLOT_W-1:0]        tail_q;
	logic [cht_pkg::SLOT_W-1:0]        next_q [cht_pkg::POOL_ENTRIES];
	cht_pkg::status_t                  pend_q;
	logic [cht_pkg::KEY_W-1:0]         key_q;
	logic [cht_pkg::VAL_W-1:0]         val_q;

	logic                              ovalid_q;
	cht_pkg::status_t                  ostat_q;
	logic [cht_pkg::KEY_W-1:0]         okey_q;
	logic [cht_pkg::VAL_W-1:0]         oval_q;
	logic                              olast_q;

	logic                              in_xfer;
	logic                              out_free;
	logic                              out_load;
	logic                              hash_start;
	cht_pkg::mod_rsp_t                 mod_rsp;
	logic [cht_pkg::SLOT_W-1:0]        slot;
	logic                              full;
	logic [cht_pkg::MAX_BUCKETS-1:0]   valid_shift;
	logic                              more_above;
	logic                              chain_end;

	// RAM ports.
	logic                              ent_we;
	cht_pkg::entry_t                   ent_wdata;
	logic                              ent_re;
	logic [cht_pkg::SLOT_W-1:0]        ent_raddr;
	cht_pkg::entry_t                   ent_rdata;
	logic                              bkt_we;
	cht_pkg::bucket_t                  bkt_wdata;
	logic                              bkt_re;
	logic [cht_pkg::BKT_W-1:0]         bkt_raddr;
	cht_pkg::bucket_t                  bkt_rdata;

	// Handshakes.
	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !ovalid_q || out_ready;
	assign out_load  = out_free && (state_q == S_EMIT || state_q == S_DOUT);
	assign out_valid = ovalid_q;
	assign status    = ostat_q;
	assign out_key   = okey_q;
	assign out_value = oval_q;
	assign last      = olast_q;

	// Effective bucket count, saturated to the range 1 to MAX_BUCKETS.
	always_comb begin
		if (bcount_q == '0) begin
			eff_buckets = (cht_pkg::BKT_W + 1)'(1);
		end else if (bcount_q > cht_pkg::CFG_W'(cht_pkg::MAX_BUCKETS)) begin
			eff_buckets = (cht_pkg::BKT_W + 1)'(cht_pkg::MAX_BUCKETS);
		end else begin
			eff_buckets = (cht_pkg::BKT_W + 1)'(bcount_q);
		end
	end

	// Dump walk helpers.
	assign slot        = used_q[cht_pkg::SLOT_W-1:0];
	assign full        = (used_q == cht_pkg::CNT_W'(cht_pkg::POOL_ENTRIES));
	assign valid_shift = bvalid_q >> bkt_q;
	assign more_above  = |valid_shift[cht_pkg::MAX_BUCKETS-1:1];
	assign chain_end   = (cur_q == tail_q);
	assign hash_start  = in_xfer && !action && !full;

	// RAM access control.
	always_comb begin
		ent_we          = 1'b0;
		ent_wdata.key   = key_q;
		ent_wdata.value = val_q;
		ent_re          = 1'b0;
		ent_raddr       = bkt_rdata.head;
		bkt_we          = 1'b0;
		bkt_wdata.head  = bvalid_q[bkt_q] ? bkt_rdata.head : slot;
		bkt_wdata.tail  = slot;
		bkt_re          = 1'b0;
		bkt_raddr       = bkt_q;
		case (state_q)
			S_HASH: begin
				bkt_re    = mod_rsp.done;
				bkt_raddr = mod_rsp.rem;
			end
			S_BRD: begin
				ent_we = 1'b1;
				bkt_we = 1'b1;
			end
			S_DSCAN: begin
				bkt_re = bvalid_q[bkt_q];
			end
			S_DHEAD: begin
				ent_re = 1'b1;
			end
			S_DOUT: begin
				ent_re    = out_free && !chain_end;
				ent_raddr = next_q[cur_q];
			end
			default: begin
			end
		endcase
	end

	// Sequencer state, counters and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			bcount_q <= cht_pkg::BUCKETS_RESET;
			used_q   <= '0;
			bvalid_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				bcount_q <= cfg_wdata;
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && out_ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (!action) begin
							state_q <= full ? S_EMIT : S_HASH;
						end else begin
							state_q <= (bvalid_q == '0) ? S_EMIT : S_DSCAN;
						end
					end
				end
				S_HASH: begin
					if (mod_rsp.done) begin
						state_q <= S_BRD;
					end
				end
				S_BRD: begin
					bvalid_q[bkt_q] <= 1'b1;
					used_q          <= used_q + 1'b1;
					state_q         <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DSCAN: begin
					if (bvalid_q[bkt_q]) begin
						state_q <= S_DHEAD;
					end
				end
				S_DHEAD: begin
					state_q <= S_DOUT;
				end
				S_DOUT: begin
					if (out_free) begin
						if (chain_end) begin
							state_q <= more_above ? S_DSCAN : S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload, walk pointers and chain links.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			key_q  <= key;
			val_q  <= value;
			bkt_q  <= '0;
			pend_q <= action ? cht_pkg::ST_EMPTY : cht_pkg::ST_FULL;
		end
		case (state_q)
			S_HASH: begin
				if (mod_rsp.done) begin
					bkt_q <= mod_rsp.rem;
				end
			end
			S_BRD: begin
				if (bvalid_q[bkt_q]) begin
					next_q[bkt_rdata.tail] <= slot;
				end
				pend_q <= cht_pkg::ST_INSERTED;
			end
			S_DSCAN: begin
				if (!bvalid_q[bkt_q]) begin
					bkt_q <= bkt_q + 1'b1;
				end
			end
			S_DHEAD: begin
				cur_q  <= bkt_rdata.head;
				tail_q <= bkt_rdata.tail;
			end
			S_DOUT: begin
				if (out_free) begin
					if (chain_end) begin
						bkt_q <= bkt_q + 1'b1;
					end else begin
						cur_q <= next_q[cur_q];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register load.
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			ostat_q <= pend_q;
			okey_q  <= '0;
			oval_q  <= '0;
			olast_q <= 1'b1;
		end else if (state_q == S_DOUT && out_free) begin
			ostat_q <= cht_pkg::ST_DUMPED;
			okey_q  <= ent_rdata.key;
			oval_q  <= ent_rdata.value;
			olast_q <= chain_end && !more_above;
		end
	end

	// Hash unit.
	cht_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (hash_start),
		.key     (key),
		.divisor (eff_buckets),
		.rsp     (mod_rsp)
	);

	// Entry pool: key and value per slot.
	cht_ram #(
		.WIDTH ($bits(cht_pkg::entry_t)),
		.DEPTH (cht_pkg::POOL_ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (slot),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	// Bucket table: head and tail slot per bucket.
	cht_ram #(
		.WIDTH ($bits(cht_pkg::bucket_t)),
		.DEPTH (cht_pkg::MAX_BUCKETS)
	) u_bucket_ram (
		.clk   (clk),
		.we    (bkt_we),
		.waddr (bkt_q),
		.wdata (bkt_wdata),
		.re    (bkt_re),
		.raddr (bkt_raddr),
		.rdata (bkt_rdata)
	);

endmodule

`default_nettype wire

// ----- src/cht_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no dependencies.
`default_nettype none

module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/cht_mod.sv -----
// Bucket hash unit: computes (3*key+1) mod n with one restoring step a cycle.
// Depends on cht_pkg for widths and the response record.
`default_nettype none

module cht_mod (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [cht_pkg::KEY_W-1:0] key,
	input  wire logic [cht_pkg::BKT_W:0]   divisor,
	output cht_pkg::mod_rsp_t             rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [cht_pkg::STEP_W-1:0]    cnt_q;
	logic [cht_pkg::DVD_W-1:0]     dvd_q;
	logic [cht_pkg::BKT_W-1:0]     rem_q;
	logic [cht_pkg::BKT_W:0]       div_q;
	logic [cht_pkg::BKT_W:0]       trial;
	logic [cht_pkg::BKT_W-1:0]     rem_next;
	logic                          last_step;

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		trial = {rem_q, dvd_q[cht_pkg::DVD_W-1]};
		if (trial >= div_q) begin
			rem_next = cht_pkg::BKT_W'(trial - div_q);
		end else begin
			rem_next = trial[cht_pkg::BKT_W-1:0];
		end
		last_step = (cnt_q == cht_pkg::STEP_W'(cht_pkg::DVD_W - 1));
	end

	// Control: busy for one step per dividend bit, then a done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend 3*key+1 fits in two bits more than the key.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {1'b0, key, 1'b0} + cht_pkg::DVD_W'(key) + cht_pkg::DVD_W'(1);
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[cht_pkg::DVD_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire
